[hdl/mrt_pkg.sv]
// ---------------------------------------------------------------------------
// mrt_pkg
// Shared codes for the mapped region table: operations, status, registers.
// ---------------------------------------------------------------------------
package mrt_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    localparam logic [1:0] REG_HEAP_SIZE  = 2'd0;
    localparam logic [1:0] REG_REGION_TOP = 2'd1;
    localparam logic [1:0] REG_USER_LIMIT = 2'd2;

    localparam logic [63:0] REGION_TOP_RESET = 64'd270582939648;

    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_UNMAP  = 2'd2;
    localparam logic [1:0] OP_HEAP   = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_ARG    = 3'd1;
    localparam logic [2:0] ST_NO_FREE    = 3'd2;
    localparam logic [2:0] ST_NO_SPACE   = 3'd3;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd4;
    localparam logic [2:0] ST_DENIED     = 3'd5;

    localparam logic [1:0] ACC_OTHER = 2'd3;

endpackage

[hdl/mrt_apb_regs.sv]
// ---------------------------------------------------------------------------
// mrt_apb_regs
// Configuration registers of the mapped region table behind an APB port.
// ---------------------------------------------------------------------------
module mrt_apb_regs #(
    parameter int ADDR_BITS = 38
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mrt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mrt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [ADDR_BITS-1:0]           heap_size,
    output logic [ADDR_BITS-1:0]           region_top,
    output logic [ADDR_BITS-1:0]           user_limit
);

    logic [ADDR_BITS-1:0] heap_reg;
    logic [ADDR_BITS-1:0] top_reg;
    logic [ADDR_BITS-1:0] ulim_reg;
    logic                 wr_en;
    logic [1:0]           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= '0;
            top_reg  <= mrt_pkg::REGION_TOP_RESET[ADDR_BITS-1:0];
            ulim_reg <= '1;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                mrt_pkg::REG_HEAP_SIZE:  heap_reg <= pwdata[ADDR_BITS-1:0];
                mrt_pkg::REG_REGION_TOP: top_reg  <= pwdata[ADDR_BITS-1:0];
                mrt_pkg::REG_USER_LIMIT: ulim_reg <= pwdata[ADDR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mrt_pkg::REG_HEAP_SIZE:
                prdata = {{(mrt_pkg::CFG_DATA_W-ADDR_BITS){1'b0}}, heap_reg};
            mrt_pkg::REG_REGION_TOP:
                prdata = {{(mrt_pkg::CFG_DATA_W-ADDR_BITS){1'b0}}, top_reg};
            mrt_pkg::REG_USER_LIMIT:
                prdata = {{(mrt_pkg::CFG_DATA_W-ADDR_BITS){1'b0}}, ulim_reg};
            default:
                prdata = '0;
        endcase
    end

    assign heap_size  = heap_reg;
    assign region_top = top_reg;
    assign user_limit = ulim_reg;

endmodule

[hdl/mapped_region_table.sv]
// ---------------------------------------------------------------------------
// mapped_region_table
// Fixed table of address regions with a top-down allocator, lookup with
// permission check, unmap with trim and split, and a heap limit query.
// ---------------------------------------------------------------------------
//  channel   dir   transaction
//  s_axis    in    one request: operation and its arguments
//  m_axis    out   one response: status and region fields
//  apb       in    heap_size, region_top, user_limit at 0x00, 0x08, 0x10
//
//  One sequencer walks the table one entry a cycle through a single read port.
//  Lookup and the heap query walk the table once (lookup stops at a hit), unmap
//  walks it twice, and map makes P gap passes over it, each after a check state;
//  P is at most N + 1.
//  Input is not ready from acceptance until the response transaction.
//  Reset clears the entry valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module mapped_region_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ADDR_BITS     = 38,
    parameter int PAGE_BITS     = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // operation, address, length, protection, sharing, region_kind,
    // file_offset, access_kind
    input  logic [((11+3*ADDR_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, result_address, result_end, result_valid_end, result_offset,
    // result_protection, result_entry
    output logic [((10+4*ADDR_BITS+7)/8)*8-1:0] m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrt_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mrt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mrt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int A      = ADDR_BITS;
    localparam int N      = TABLE_ENTRIES;
    localparam int IW     = $clog2(N);
    localparam int ITW    = $clog2(N + 2);
    localparam int IN_W   = ((11 + 3*A + 7) / 8) * 8;
    localparam int OUT_W  = ((10 + 4*A + 7) / 8) * 8;
    localparam int O_ADDR = 2;
    localparam int O_LEN  = 2 + A;
    localparam int O_PROT = 2 + 2*A;
    localparam int O_SHR  = 5 + 2*A;
    localparam int O_KIND = 7 + 2*A;
    localparam int O_FOFF = 9 + 2*A;
    localparam int O_ACC  = 9 + 3*A;

    localparam logic [A:0]     PMASK     = {{(A+1-PAGE_BITS){1'b0}}, {PAGE_BITS{1'b1}}};
    localparam logic [IW-1:0]  IDX_LAST  = IW'(N - 1);
    localparam logic [ITW-1:0] ITER_LAST = ITW'(N + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PASS   = 3'd2;
    localparam logic [2:0] S_GAP    = 3'd3;
    localparam logic [2:0] S_LOOK   = 3'd4;
    localparam logic [2:0] S_UNMAP1 = 3'd5;
    localparam logic [2:0] S_UNMAP2 = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;
    localparam logic [2:0] S_HEAP   = 3'd2;

    logic [A-1:0] heap_size;
    logic [A-1:0] region_top;
    logic [A-1:0] user_limit;

    mrt_apb_regs #(
        .ADDR_BITS (A)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .heap_size  (heap_size),
        .region_top (region_top),
        .user_limit (user_limit)
    );

    // table storage
    logic [N-1:0] used_reg, used_next;
    logic [A-1:0] start_mem [N];
    logic [A-1:0] end_mem   [N];
    logic [A-1:0] vend_mem  [N];
    logic [A-1:0] off_mem   [N];
    logic [2:0]   prot_mem  [N];
    logic [1:0]   shr_mem   [N];
    logic [1:0]   kind_mem  [N];

    // control
    logic [2:0]     state_reg, state_next;
    logic           heap_op_reg, heap_op_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [ITW-1:0] iter_reg, iter_next;
    logic           best_found_reg, best_found_next;
    logic           found_reg, found_next;
    logic           split_reg, split_next;
    logic           slot_valid_reg, slot_valid_next;

    // request
    logic [1:0]   op_reg, op_next;
    logic [A-1:0] addr_reg, addr_next;
    logic [A-1:0] len_reg, len_next;
    logic [2:0]   prot_reg, prot_next;
    logic [1:0]   shr_reg, shr_next;
    logic [1:0]   kind_reg, kind_next;
    logic [A-1:0] foff_reg, foff_next;
    logic [1:0]   acc_reg, acc_next;

    // working values
    logic [A-1:0]  mlen_reg, mlen_next;
    logic [A-1:0]  bottom_reg, bottom_next;
    logic [A-1:0]  top_reg, top_next;
    logic [A-1:0]  gstart_reg, gstart_next;
    logic [A-1:0]  best_start_reg, best_start_next;
    logic [A-1:0]  uend_reg, uend_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic [IW-1:0] slot_reg, slot_next;

    // response
    logic [2:0]   st_out_reg, st_out_next;
    logic [A-1:0] res_addr_reg, res_addr_next;
    logic [A-1:0] res_end_reg, res_end_next;
    logic [A-1:0] res_vend_reg, res_vend_next;
    logic [A-1:0] res_off_reg, res_off_next;
    logic [2:0]   res_prot_reg, res_prot_next;
    logic [3:0]   res_entry_reg, res_entry_next;

    // read port
    logic         rd_used;
    logic [A-1:0] rd_start, rd_end, rd_vend, rd_off;
    logic [2:0]   rd_prot;
    logic [1:0]   rd_shr, rd_kind;

    // write ports
    logic          wa_en, wa_used, wb_en;
    logic [IW-1:0] wa_idx, wb_idx;
    logic [A-1:0]  wa_start, wa_end, wa_vend, wa_off;
    logic [A-1:0]  wb_start, wb_end, wb_vend, wb_off;
    logic [2:0]    wa_prot, wb_prot;
    logic [1:0]    wa_shr, wa_kind, wb_shr, wb_kind;

    // free entry search
    logic          free_any;
    logic [IW-1:0] free_idx;

    logic [A:0]    mlen_full, bottom_full, usum_full, uend_full;
    logic          map_bad, unmap_bad;
    logic          ov_gap, cand, nf;
    logic [A-1:0]  ns;
    logic          ov_un, hit, last;
    logic          found_now, split_now;
    logic [A-1:0]  s_lo, f_hi;
    logic [IW+3:0] ent_ext, idx_ext;

    assign rd_used  = used_reg[idx_reg];
    assign rd_start = start_mem[idx_reg];
    assign rd_end   = end_mem[idx_reg];
    assign rd_vend  = vend_mem[idx_reg];
    assign rd_off   = off_mem[idx_reg];
    assign rd_prot  = prot_mem[idx_reg];
    assign rd_shr   = shr_mem[idx_reg];
    assign rd_kind  = kind_mem[idx_reg];

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign ent_ext = {4'b0000, ent_reg};
    assign idx_ext = {4'b0000, idx_reg};
    assign last    = (idx_reg == IDX_LAST);

    assign mlen_full   = ({1'b0, len_reg} + PMASK) & ~PMASK;
    assign bottom_full = ({1'b0, heap_size} + PMASK) & ~PMASK;
    assign usum_full   = {1'b0, addr_reg} + {1'b0, len_reg};
    assign uend_full   = (usum_full + PMASK) & ~PMASK;

    assign map_bad = (addr_reg != '0) || (len_reg == '0) || (len_reg > region_top) ||
                     (prot_reg[1] && !prot_reg[0]) ||
                     (shr_reg != 2'd1 && shr_reg != 2'd2) || mlen_full[A];
    assign unmap_bad = (len_reg == '0) || (addr_reg[PAGE_BITS-1:0] != '0) ||
                       (addr_reg >= region_top) || (len_reg > region_top - addr_reg) ||
                       (uend_full > {1'b0, region_top});

    assign ov_gap = rd_used && (gstart_reg < rd_end) && (rd_start < top_reg);
    assign cand   = ov_gap && (!best_found_reg || rd_start > best_start_reg);
    assign nf     = best_found_reg | cand;
    assign ns     = cand ? rd_start : best_start_reg;

    assign ov_un     = rd_used && (addr_reg < rd_end) && (rd_start < uend_reg);
    assign found_now = found_reg | ov_un;
    assign split_now = split_reg | (ov_un && rd_start < addr_reg && uend_reg < rd_end);
    assign s_lo      = (addr_reg > rd_start) ? addr_reg : rd_start;
    assign f_hi      = (uend_reg < rd_end) ? uend_reg : rd_end;

    assign hit = rd_used && (rd_start <= addr_reg) && (addr_reg < rd_end);

    always_comb
    begin
        state_next      = state_reg;
        heap_op_next    = heap_op_reg;
        idx_next        = idx_reg;
        iter_next       = iter_reg;
        best_found_next = best_found_reg;
        found_next      = found_reg;
        split_next      = split_reg;
        slot_valid_next = slot_valid_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        prot_next       = prot_reg;
        shr_next        = shr_reg;
        kind_next       = kind_reg;
        foff_next       = foff_reg;
        acc_next        = acc_reg;
        mlen_next       = mlen_reg;
        bottom_next     = bottom_reg;
        top_next        = top_reg;
        gstart_next     = gstart_reg;
        best_start_next = best_start_reg;
        uend_next       = uend_reg;
        ent_next        = ent_reg;
        slot_next       = slot_reg;
        st_out_next     = st_out_reg;
        res_addr_next   = res_addr_reg;
        res_end_next    = res_end_reg;
        res_vend_next   = res_vend_reg;
        res_off_next    = res_off_reg;
        res_prot_next   = res_prot_reg;
        res_entry_next  = res_entry_reg;

        wa_en    = 1'b0;
        wa_idx   = idx_reg;
        wa_used  = 1'b1;
        wa_start = rd_start;
        wa_end   = rd_end;
        wa_vend  = rd_vend;
        wa_off   = rd_off;
        wa_prot  = rd_prot;
        wa_shr   = rd_shr;
        wa_kind  = rd_kind;
        wb_en    = 1'b0;
        wb_idx   = slot_valid_reg ? slot_reg : free_idx;
        wb_start = f_hi;
        wb_end   = rd_end;
        wb_vend  = rd_vend;
        wb_off   = rd_off + (f_hi - rd_start);
        wb_prot  = rd_prot;
        wb_shr   = rd_shr;
        wb_kind  = rd_kind;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next        = s_axis_tdata[1:0];
                    addr_next      = s_axis_tdata[O_ADDR +: A];
                    len_next       = s_axis_tdata[O_LEN +: A];
                    prot_next      = s_axis_tdata[O_PROT +: 3];
                    shr_next       = s_axis_tdata[O_SHR +: 2];
                    kind_next      = s_axis_tdata[O_KIND +: 2];
                    foff_next      = s_axis_tdata[O_FOFF +: A];
                    acc_next       = s_axis_tdata[O_ACC +: 2];
                    st_out_next    = mrt_pkg::ST_OK;
                    res_addr_next  = '0;
                    res_end_next   = '0;
                    res_vend_next  = '0;
                    res_off_next   = '0;
                    res_prot_next  = '0;
                    res_entry_next = '0;
                    heap_op_next   = 1'b0;
                    state_next     = S_CHECK;
                end
            end
            S_CHECK:
            begin
                idx_next = '0;
                case (op_reg)
                    mrt_pkg::OP_MAP:
                    begin
                        mlen_next       = mlen_full[A-1:0];
                        bottom_next     = bottom_full[A-1:0];
                        top_next        = region_top;
                        iter_next       = '0;
                        ent_next        = free_idx;
                        if (map_bad)
                        begin
                            st_out_next = mrt_pkg::ST_BAD_ARG;
                            state_next  = S_DONE;
                        end
                        else if (!free_any)
                        begin
                            st_out_next = mrt_pkg::ST_NO_FREE;
                            state_next  = S_DONE;
                        end
                        else if (bottom_full > {1'b0, region_top})
                        begin
                            st_out_next = mrt_pkg::ST_NO_SPACE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next  = S_PASS;
                        end
                    end
                    mrt_pkg::OP_LOOKUP:
                    begin
                        if (addr_reg >= user_limit)
                        begin
                            st_out_next = mrt_pkg::ST_NOT_MAPPED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next  = S_LOOK;
                        end
                    end
                    mrt_pkg::OP_UNMAP:
                    begin
                        uend_next  = uend_full[A-1:0];
                        found_next = 1'b0;
                        split_next = 1'b0;
                        if (unmap_bad)
                        begin
                            st_out_next = mrt_pkg::ST_BAD_ARG;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next  = S_UNMAP1;
                        end
                    end
                    default:
                    begin
                        res_addr_next = region_top;
                        heap_op_next  = 1'b1;
                        state_next    = S_HEAP;
                    end
                endcase
            end
            S_PASS:
            begin
                if (heap_op_reg)
                begin
                    if (rd_used && rd_start < res_addr_reg)
                    begin
                        res_addr_next = rd_start;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (last)
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (iter_reg == ITER_LAST || top_reg < bottom_reg ||
                         (top_reg - bottom_reg) < mlen_reg)
                begin
                    st_out_next = mrt_pkg::ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    gstart_next     = top_reg - mlen_reg;
                    best_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = S_GAP;
                end
            end
            S_GAP:
            begin
                idx_next        = idx_reg + 1'b1;
                best_found_next = nf;
                best_start_next = ns;
                if (last)
                begin
                    if (nf)
                    begin
                        top_next   = ns;
                        iter_next  = iter_reg + 1'b1;
                        state_next = S_PASS;
                    end
                    else if (gstart_reg == '0)
                    begin
                        st_out_next = mrt_pkg::ST_NO_SPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        wa_en          = 1'b1;
                        wa_idx         = ent_reg;
                        wa_used        = 1'b1;
                        wa_start       = gstart_reg;
                        wa_end         = gstart_reg + mlen_reg;
                        wa_vend        = gstart_reg + len_reg;
                        wa_off         = foff_reg;
                        wa_prot        = prot_reg;
                        wa_shr         = shr_reg;
                        wa_kind        = kind_reg;
                        res_addr_next  = gstart_reg;
                        res_entry_next = ent_ext[3:0];
                        state_next     = S_DONE;
                    end
                end
            end
            S_LOOK:
            begin
                idx_next = idx_reg + 1'b1;
                if (hit)
                begin
                    res_addr_next  = rd_start;
                    res_end_next   = rd_end;
                    res_vend_next  = rd_vend;
                    res_off_next   = rd_off;
                    res_prot_next  = rd_prot;
                    res_entry_next = idx_ext[3:0];
                    if (acc_reg != mrt_pkg::ACC_OTHER && rd_prot[acc_reg])
                    begin
                        st_out_next = mrt_pkg::ST_OK;
                    end
                    else
                    begin
                        st_out_next = mrt_pkg::ST_DENIED;
                    end
                    state_next = S_DONE;
                end
                else if (last)
                begin
                    st_out_next = mrt_pkg::ST_NOT_MAPPED;
                    state_next  = S_DONE;
                end
            end
            S_UNMAP1:
            begin
                idx_next   = idx_reg + 1'b1;
                found_next = found_now;
                split_next = split_now;
                if (last)
                begin
                    slot_valid_next = split_now;
                    slot_next       = free_idx;
                    if (!found_now)
                    begin
                        st_out_next = mrt_pkg::ST_NOT_MAPPED;
                        state_next  = S_DONE;
                    end
                    else if (split_now && !free_any)
                    begin
                        st_out_next = mrt_pkg::ST_NO_FREE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next  = S_UNMAP2;
                    end
                end
            end
            S_UNMAP2:
            begin
                idx_next = idx_reg + 1'b1;
                if (ov_un)
                begin
                    wa_en = 1'b1;
                    if (s_lo == rd_start && f_hi == rd_end)
                    begin
                        wa_used = 1'b0;
                    end
                    else if (s_lo == rd_start)
                    begin
                        wa_start = f_hi;
                        wa_off   = rd_off + (f_hi - rd_start);
                    end
                    else
                    begin
                        if (f_hi != rd_end && (slot_valid_reg || free_any))
                        begin
                            wb_en           = 1'b1;
                            slot_valid_next = 1'b0;
                        end
                        wa_end = s_lo;
                        if (rd_vend > s_lo)
                        begin
                            wa_vend = s_lo;
                        end
                    end
                end
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            default:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (wa_en)
        begin
            used_next[wa_idx] = wa_used;
        end
        if (wb_en)
        begin
            used_next[wb_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_op_reg    <= 1'b0;
            idx_reg        <= '0;
            iter_reg       <= '0;
            best_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            split_reg      <= 1'b0;
            slot_valid_reg <= 1'b0;
            used_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            heap_op_reg    <= heap_op_next;
            idx_reg        <= idx_next;
            iter_reg       <= iter_next;
            best_found_reg <= best_found_next;
            found_reg      <= found_next;
            split_reg      <= split_next;
            slot_valid_reg <= slot_valid_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        prot_reg       <= prot_next;
        shr_reg        <= shr_next;
        kind_reg       <= kind_next;
        foff_reg       <= foff_next;
        acc_reg        <= acc_next;
        mlen_reg       <= mlen_next;
        bottom_reg     <= bottom_next;
        top_reg        <= top_next;
        gstart_reg     <= gstart_next;
        best_start_reg <= best_start_next;
        uend_reg       <= uend_next;
        ent_reg        <= ent_next;
        slot_reg       <= slot_next;
        st_out_reg     <= st_out_next;
        res_addr_reg   <= res_addr_next;
        res_end_reg    <= res_end_next;
        res_vend_reg   <= res_vend_next;
        res_off_reg    <= res_off_next;
        res_prot_reg   <= res_prot_next;
        res_entry_reg  <= res_entry_next;
        if (wa_en)
        begin
            start_mem[wa_idx] <= wa_start;
            end_mem[wa_idx]   <= wa_end;
            vend_mem[wa_idx]  <= wa_vend;
            off_mem[wa_idx]   <= wa_off;
            prot_mem[wa_idx]  <= wa_prot;
            shr_mem[wa_idx]   <= wa_shr;
            kind_mem[wa_idx]  <= wa_kind;
        end
        if (wb_en)
        begin
            start_mem[wb_idx] <= wb_start;
            end_mem[wb_idx]   <= wb_end;
            vend_mem[wb_idx]  <= wb_vend;
            off_mem[wb_idx]   <= wb_off;
            prot_mem[wb_idx]  <= wb_prot;
            shr_mem[wb_idx]   <= wb_shr;
            kind_mem[wb_idx]  <= wb_kind;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_DONE);
    assign m_axis_tdata  = OUT_W'({res_entry_reg, res_prot_reg, res_off_reg, res_vend_reg,
                                   res_end_reg, res_addr_reg, st_out_reg});

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a response is pending");

    a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("no return to idle after response transaction");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st_out_reg != mrt_pkg::ST_OK && st_out_reg != mrt_pkg::ST_DENIED)
        |-> (res_addr_reg == '0 && res_entry_reg == '0))
        else $error("failed response carries region fields");

    a_two_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (wa_en && wb_en) |-> (wa_idx != wb_idx))
        else $error("split entry collides with trimmed entry");
`endif

endmodule

[verif/mrt_checker.sv]
// ----------------------------------------------------------------------------
// mrt_checker
// Watches the request, response and register channels of the mapped region
// table. It keeps its own copy of the region table and the registers, works
// out the response for each request it sees accepted, and compares every
// accepted response field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mrt_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [167:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N = 16;
    localparam logic [63:0] AMASK = (64'd1 << 38) - 64'd1;
    localparam logic [63:0] PMASK = 64'hFFF;

    typedef struct {
        logic [2:0]  status;
        logic [37:0] addr;
        logic [37:0] rend;
        logic [37:0] vend;
        logic [37:0] offs;
        logic [2:0]  prot;
        logic [3:0]  entry;
    } response_t;

    response_t   resp_q[$];
    logic [37:0] heap_size, region_top, user_limit;
    bit          used[N];
    logic [37:0] r_start[N], r_end[N], r_vend[N], r_offs[N];
    logic [2:0]  r_prot[N];
    logic [1:0]  r_shr[N], r_kind[N];

    function automatic logic [63:0] page_up(logic [63:0] x);
        return (x + PMASK) & ~PMASK;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < N; i++)
            if (!used[i])
                return i;
        return -1;
    endfunction

    function automatic bit hits(int i, logic [63:0] s, logic [63:0] e);
        return used[i] && s < 64'(r_end[i]) && 64'(r_start[i]) < e;
    endfunction

    function automatic void wipe(int i);
        used[i] = 0;
        r_start[i] = '0; r_end[i] = '0; r_vend[i] = '0; r_offs[i] = '0;
        r_prot[i] = '0; r_shr[i] = '0; r_kind[i] = '0;
    endfunction

    function automatic logic [63:0] highest_gap(logic [63:0] len);
        logic [63:0] bottom;
        logic [63:0] top;
        logic [63:0] start;
        int best;
        bottom = page_up(64'(heap_size));
        top = 64'(region_top);
        if (bottom > AMASK || bottom > top)
            return 0;
        for (int it = 0; it <= N; it++)
        begin
            if (top < bottom || top - bottom < len)
                return 0;
            start = top - len;
            best = -1;
            for (int i = 0; i < N; i++)
                if (hits(i, start, top) && (best < 0 || r_start[i] > r_start[best]))
                    best = i;
            if (best < 0)
                return start;
            top = 64'(r_start[best]);
        end
        return 0;
    endfunction

    function automatic void do_map(logic [127:0] d, ref response_t r);
        logic [63:0] len;
        logic [63:0] mlen;
        logic [63:0] start;
        logic [2:0]  prot;
        logic [1:0]  shr;
        int e;
        len = 64'(d[77:40]);
        prot = d[80:78];
        shr = d[82:81];
        if (d[39:2] != 0 || len == 0 || len > 64'(region_top) || (prot[1] && !prot[0])
            || (shr != 2'd1 && shr != 2'd2))
        begin
            r.status = mrt_pkg::ST_BAD_ARG;
            return;
        end
        mlen = page_up(len);
        if (mlen > AMASK)
        begin
            r.status = mrt_pkg::ST_BAD_ARG;
            return;
        end
        e = first_free();
        if (e < 0)
        begin
            r.status = mrt_pkg::ST_NO_FREE;
            return;
        end
        start = highest_gap(mlen);
        if (start == 0)
        begin
            r.status = mrt_pkg::ST_NO_SPACE;
            return;
        end
        used[e] = 1;
        r_kind[e] = d[84:83];
        r_start[e] = start[37:0];
        r_end[e] = 38'(start + mlen);
        r_vend[e] = 38'(start + len);
        r_offs[e] = d[122:85];
        r_prot[e] = prot;
        r_shr[e] = shr;
        r.addr = start[37:0];
        r.entry = 4'(e);
    endfunction

    function automatic void do_lookup(logic [127:0] d, ref response_t r);
        logic [37:0] va;
        logic [1:0]  acc;
        int f;
        va = d[39:2];
        acc = d[124:123];
        f = -1;
        if (va >= user_limit)
        begin
            r.status = mrt_pkg::ST_NOT_MAPPED;
            return;
        end
        for (int i = 0; i < N; i++)
            if (f < 0 && used[i] && r_start[i] <= va && va < r_end[i])
                f = i;
        if (f < 0)
        begin
            r.status = mrt_pkg::ST_NOT_MAPPED;
            return;
        end
        r.addr = r_start[f];
        r.rend = r_end[f];
        r.vend = r_vend[f];
        r.offs = r_offs[f];
        r.prot = r_prot[f];
        r.entry = 4'(f);
        if (acc == mrt_pkg::ACC_OTHER || !r_prot[f][acc])
            r.status = mrt_pkg::ST_DENIED;
    endfunction

    function automatic logic [2:0] do_unmap(logic [127:0] d);
        logic [63:0] a;
        logic [63:0] len;
        logic [63:0] e;
        logic [63:0] os;
        logic [63:0] oe;
        logic [63:0] s;
        logic [63:0] f;
        bit found;
        bit split;
        int slot;
        a = 64'(d[39:2]);
        len = 64'(d[77:40]);
        found = 0;
        split = 0;
        slot = -1;
        if (len == 0 || (a & PMASK) != 0 || a >= 64'(region_top))
            return mrt_pkg::ST_BAD_ARG;
        if (len > 64'(region_top) - a)
            return mrt_pkg::ST_BAD_ARG;
        e = page_up(a + len);
        if (e > 64'(region_top))
            return mrt_pkg::ST_BAD_ARG;
        for (int i = 0; i < N; i++)
            if (hits(i, a, e))
            begin
                found = 1;
                if (64'(r_start[i]) < a && e < 64'(r_end[i]))
                    split = 1;
            end
        if (!found)
            return mrt_pkg::ST_NOT_MAPPED;
        if (split)
        begin
            slot = first_free();
            if (slot < 0)
                return mrt_pkg::ST_NO_FREE;
        end
        for (int i = 0; i < N; i++)
        begin
            if (!hits(i, a, e))
                continue;
            os = 64'(r_start[i]);
            oe = 64'(r_end[i]);
            s = a > os ? a : os;
            f = e < oe ? e : oe;
            if (s == os && f == oe)
                wipe(i);
            else if (s == os)
            begin
                r_start[i] = f[37:0];
                r_offs[i] = 38'(64'(r_offs[i]) + (f - os));
            end
            else
            begin
                if (f != oe)
                begin
                    if (slot < 0)
                        slot = first_free();
                    if (slot >= 0)
                    begin
                        used[slot] = 1;
                        r_start[slot] = f[37:0];
                        r_end[slot] = oe[37:0];
                        r_vend[slot] = r_vend[i];
                        r_offs[slot] = 38'(64'(r_offs[i]) + (f - os));
                        r_prot[slot] = r_prot[i];
                        r_shr[slot] = r_shr[i];
                        r_kind[slot] = r_kind[i];
                        slot = -1;
                    end
                end
                r_end[i] = s[37:0];
                if (64'(r_vend[i]) > s)
                    r_vend[i] = s[37:0];
            end
        end
        return mrt_pkg::ST_OK;
    endfunction

    function automatic response_t predict_response(logic [127:0] d);
        response_t r;
        logic [37:0] lim;
        r = '{default: '0};
        case (d[1:0])
            mrt_pkg::OP_MAP:    do_map(d, r);
            mrt_pkg::OP_LOOKUP: do_lookup(d, r);
            mrt_pkg::OP_UNMAP:  r.status = do_unmap(d);
            default:
            begin
                lim = region_top;
                for (int i = 0; i < N; i++)
                    if (used[i] && r_start[i] < lim)
                        lim = r_start[i];
                r.addr = lim;
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        response_t w;
        if (!rst_n)
        begin
            heap_size <= '0;
            region_top <= mrt_pkg::REGION_TOP_RESET[37:0];
            user_limit <= '1;
            for (int i = 0; i < N; i++)
                wipe(i);
            resp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                case (paddr[4:3])
                    mrt_pkg::REG_HEAP_SIZE:  heap_size <= pwdata[37:0];
                    mrt_pkg::REG_REGION_TOP: region_top <= pwdata[37:0];
                    mrt_pkg::REG_USER_LIMIT: user_limit <= pwdata[37:0];
                    default: ;
                endcase
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(predict_response(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (resp_q.size() == 0)
                    report("unexpected transaction", 64'(m_axis_tdata[2:0]), 0);
                else
                begin
                    w = resp_q.pop_front();
                    if (m_axis_tdata[2:0] != w.status)
                        report("status", 64'(m_axis_tdata[2:0]), 64'(w.status));
                    if (m_axis_tdata[40:3] != w.addr)
                        report("address", 64'(m_axis_tdata[40:3]), 64'(w.addr));
                    if (m_axis_tdata[78:41] != w.rend)
                        report("end", 64'(m_axis_tdata[78:41]), 64'(w.rend));
                    if (m_axis_tdata[116:79] != w.vend)
                        report("valid end", 64'(m_axis_tdata[116:79]), 64'(w.vend));
                    if (m_axis_tdata[154:117] != w.offs)
                        report("offset", 64'(m_axis_tdata[154:117]), 64'(w.offs));
                    if (m_axis_tdata[157:155] != w.prot)
                        report("protection", 64'(m_axis_tdata[157:155]), 64'(w.prot));
                    if (m_axis_tdata[161:158] != w.entry)
                        report("entry", 64'(m_axis_tdata[161:158]), 64'(w.entry));
                end
            end
            pending <= resp_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the mapped region table through directed requests and several
// register settings with mostly well-formed random requests, bursty input
// and a stalling receiver; the checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] AMAX = (64'd1 << 38) - 64'd1;
    localparam int IDLE_LIMIT = 20000;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    // operation, address, length, protection, sharing, region_kind,
    // file_offset, access_kind
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    // status, result_address, result_end, result_valid_end, result_offset,
    // result_protection, result_entry
    logic [167:0] m_axis_tdata;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    int           burst_left = 1;
    int           idle_cycles = 0;
    int           stall_mode = 0;
    int           mode_cycles = 0;
    logic [63:0]  cur_top = 64'd270582939648;

    mapped_region_table u_top (.*);

    mrt_checker u_chk (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (mode_cycles == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(50, 400);
        end
        else
            mode_cycles <= mode_cycles - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel || (!s_axis_tvalid && pending == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [127:0] pack_req(logic [1:0] op, logic [63:0] a, logic [63:0] len,
                                              logic [2:0] prot, logic [1:0] shr,
                                              logic [1:0] kind, logic [63:0] offs,
                                              logic [1:0] acc);
        return {3'b0, acc, offs[37:0], kind, shr, prot, len[37:0], a[37:0], op};
    endfunction

    function automatic logic [63:0] rand38();
        return {$urandom, $urandom} & AMAX;
    endfunction

    task automatic send(logic [127:0] d);
        int gap;
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [63:0] heap, logic [63:0] top, logic [63:0] ulim);
        drain();
        write_reg(mrt_pkg::REG_HEAP_SIZE, heap);
        write_reg(mrt_pkg::REG_REGION_TOP, top);
        write_reg(mrt_pkg::REG_USER_LIMIT, ulim);
        cur_top = top;
    endtask

    task automatic random_item();
        logic [63:0] a;
        logic [63:0] len;
        logic [2:0]  prot;
        int pick;
        pick = $urandom_range(0, 99);
        a = cur_top - 64'($urandom_range(0, 40)) * 64'h1000;
        if (pick < 12)
            send({$urandom, $urandom, $urandom, $urandom});
        else if (pick < 47)
        begin
            len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(1, 1 << 20))
                                              : 64'($urandom_range(1, 8 * 4096));
            prot = 3'($urandom_range(0, 7));
            if (prot[1])
                prot[0] = 1'b1;
            send(pack_req(mrt_pkg::OP_MAP, 0, len, prot, 2'($urandom_range(1, 2)),
                          2'($urandom_range(0, 3)), rand38(), 2'($urandom_range(0, 3))));
        end
        else if (pick < 75)
            send(pack_req(mrt_pkg::OP_LOOKUP, (a + 64'($urandom_range(0, 4095))) & AMAX,
                          rand38(), 3'($urandom), 2'($urandom), 2'($urandom), rand38(),
                          2'($urandom_range(0, 3))));
        else if (pick < 92)
        begin
            len = ($urandom_range(0, 7) == 0) ? 64'h40000 : 64'($urandom_range(1, 6 * 4096));
            send(pack_req(mrt_pkg::OP_UNMAP, a & AMAX & ~64'hFFF, len, 3'($urandom),
                          2'($urandom), 2'($urandom), rand38(), 2'($urandom)));
        end
        else
            send(pack_req(mrt_pkg::OP_HEAP, rand38(), rand38(), 3'($urandom), 2'($urandom),
                          2'($urandom), rand38(), 2'($urandom)));
    endtask

    task automatic random_phase(int count);
        repeat (count) random_item();
    endtask

    initial
    begin
        logic [63:0] t;
        t = 64'd270582939648;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        send(pack_req(mrt_pkg::OP_MAP, 0, 1, 3'd1, 2'd1, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, 64'h2000, 3'd7, 2'd2, 2'd3, AMAX, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, AMAX, 3'd1, 2'd1, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 64'h1000, 1, 3'd1, 2'd1, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, 0, 3'd1, 2'd1, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, 1, 3'd2, 2'd1, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, 1, 3'd1, 2'd0, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_MAP, 0, 1, 3'd1, 2'd3, 2'd0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_LOOKUP, t - 1, 0, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_LOOKUP, t - 1, 0, 0, 0, 0, 0, 2'd1));
        send(pack_req(mrt_pkg::OP_LOOKUP, t - 64'h2000, 0, 0, 0, 0, 0, 2'd2));
        send(pack_req(mrt_pkg::OP_LOOKUP, t - 64'h2000, 0, 0, 0, 0, 0, mrt_pkg::ACC_OTHER));
        send(pack_req(mrt_pkg::OP_LOOKUP, AMAX, 0, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_HEAP, 0, 0, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h2800, 64'h1000, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h2000, 0, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t, 64'h1000, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h1000, AMAX, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h2000, 64'h1000, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h1000, 1, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h1000, 64'h1000, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_UNMAP, t - 64'h8000, 64'h8000, 0, 0, 0, 0, 2'd0));
        send(pack_req(mrt_pkg::OP_HEAP, 0, 0, 0, 0, 0, 0, 2'd0));

        random_phase(300);
        configure(64'h100000 - 64'h20000 + 1, 64'h100000, 64'h100000 - 64'h8000);
        random_phase(300);
        configure(0, 64'h40000, AMAX);
        random_phase(300);
        configure(AMAX, AMAX, 0);
        random_phase(150);
        configure(64'h3000, AMAX & ~64'hFFF, AMAX);
        random_phase(150);
        configure(0, 0, AMAX);
        random_phase(100);
        configure(64'h3000, t, t - 64'h10000);
        random_phase(400);

        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hdl/mrt_pkg.sv
hdl/mrt_apb_regs.sv
hdl/mapped_region_table.sv
verif/mrt_checker.sv
verif/tb_top.sv
